>>> rtl/assert_macros.svh
// Assertion helpers. They expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define RGBHUE_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rgbhue: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define RGBHUE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgbhue: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RGBHUE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgbhue: assertion failed");

`endif

>>> rtl/rgbhue_pkg.sv
package rgbhue_pkg;

  localparam int unsigned MAX_PIXELS_DEFAULT = 262144;

  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned HUE_W     = 8;
  localparam int unsigned RCOUNT_W  = 19;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned THR_W     = 5;

  // Every quotient the block needs (hue offset, percentage) is below 128.
  localparam int unsigned Q_W       = 7;
  localparam int unsigned STEP_W    = 3;
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(Q_W - 1);

  localparam logic [THR_W-1:0] GREY_THR_RESET = 5'd10;
  localparam logic [HUE_W-1:0] HUE_GREY       = 8'd255;
  localparam logic [8:0]       HUE_CIRCLE     = 9'd192;
  localparam logic [8:0]       HUE_BASE_RED   = 9'd0;
  localparam logic [8:0]       HUE_BASE_GREEN = 9'd64;
  localparam logic [8:0]       HUE_BASE_BLUE  = 9'd128;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last_in_frame;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]    hue;
    logic                is_rain;
    logic [RCOUNT_W-1:0] rain_count;
    logic [PCT_W-1:0]    cover_percent;
    logic                frame_done;
  } res_t;

  typedef struct packed {
    logic              capture;
    logic              cnt_update;
    logic              load_hue;
    logic              load_pct;
    logic              div_step;
    logic [STEP_W-1:0] step_idx;
    logic              hue_save;
    logic              out_load;
    logic              cnt_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/rgb565_hue_rain_counter.sv
// Each accepted pixel beat is decoded and divided for its hue, and on the last pixel
// of a frame also divided for the percentage, before its result beat is loaded.
// Pixels are taken one at a time: in_stall_o stays high until the result is loaded.
// The shared 7-step restoring divider runs for the hue, then for the percentage.
// Reset clears both frame counters, empties the result register, and sets the grey
// threshold to 10.
module rgb565_hue_rain_counter #(
  parameter int unsigned MAX_PIXELS = rgbhue_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rgbhue_pkg::pix_in_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rgbhue_pkg::res_t             out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rgbhue_pkg::THR_W-1:0] cfg_data_i
);

  rgbhue_pkg::ctrl_cmd_t cmd;
  rgbhue_pkg::ctrl_sts_t sts;

  rgbhue_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rgbhue_dp #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/rgbhue_div.sv
module rgbhue_div #(
  parameter int unsigned DEN_W = 19
) (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic                             step_i,
  input  logic [rgbhue_pkg::STEP_W-1:0]    step_idx_i,
  input  logic [DEN_W+rgbhue_pkg::Q_W-1:0] num_i,
  input  logic [DEN_W-1:0]                 den_i,
  output logic [rgbhue_pkg::Q_W-1:0]       quot_o
);

  localparam int unsigned DIV_W = DEN_W + rgbhue_pkg::Q_W;

  logic [DIV_W-1:0]             rem_q, rem_d;
  logic [DEN_W-1:0]             den_q;
  logic [rgbhue_pkg::Q_W-1:0]   quot_q, quot_d;
  logic [DIV_W-1:0]             den_sh;
  logic                         fits;

  // Restoring division, one quotient bit a beat from the top bit down.
  always_comb begin
    den_sh = DIV_W'(den_q) << step_idx_i;
    fits   = rem_q >= den_sh;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (load_i) begin
      rem_d  = num_i;
      quot_d = '0;
    end else if (step_i) begin
      if (fits) begin
        rem_d = rem_q - den_sh;
      end
      quot_d[step_idx_i] = fits;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (load_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o = quot_q;

endmodule

>>> rtl/rgbhue_ctrl.sv
`include "assert_macros.svh"

module rgbhue_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rgbhue_pkg::ctrl_sts_t  sts_i,
  output rgbhue_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_HDIV  = 3'd2;
  localparam logic [2:0] S_HSAVE = 3'd3;
  localparam logic [2:0] S_PDIV  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [rgbhue_pkg::STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step_idx = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.cnt_update = 1'b1;
        cmd_o.load_hue   = 1'b1;
        step_d           = rgbhue_pkg::STEP_FIRST;
        state_d          = S_HDIV;
      end
      S_HDIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = S_HSAVE;
        end
      end
      S_HSAVE: begin
        // The hue quotient is taken before the divider is reloaded for the percentage.
        cmd_o.hue_save = 1'b1;
        if (sts_i.last) begin
          cmd_o.load_pct = 1'b1;
          step_d         = rgbhue_pkg::STEP_FIRST;
          state_d        = S_PDIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_PDIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.cnt_clear = sts_i.last;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `RGBHUE_ASSERT_IMP(a_load_only_free, cmd_o.out_load, sts_i.out_free)
  `RGBHUE_ASSERT_NXT(a_hdiv_ends, (state_q == S_HDIV) && (step_q == '0), state_q == S_HSAVE)
  `RGBHUE_ASSERT_IMP(a_pct_on_last, cmd_o.load_pct || cmd_o.cnt_clear, sts_i.last)

endmodule

>>> rtl/rgbhue_dp.sv
`include "assert_macros.svh"

module rgbhue_dp #(
  parameter int unsigned MAX_PIXELS = rgbhue_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rgbhue_pkg::pix_in_t                 in_data_i,
  input  logic                                cfg_we_i,
  input  logic [rgbhue_pkg::THR_W-1:0]        cfg_data_i,
  input  rgbhue_pkg::ctrl_cmd_t               cmd_i,
  output rgbhue_pkg::ctrl_sts_t               sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rgbhue_pkg::res_t                    out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned DEN_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int unsigned DIV_W = DEN_W + rgbhue_pkg::Q_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [rgbhue_pkg::THR_W-1:0]  thr_q;
  logic [rgbhue_pkg::PIXEL_W-1:0] pix_q;
  logic                          last_q;
  logic                          grey_q, neg_q;
  logic [8:0]                    base_q;
  logic [rgbhue_pkg::HUE_W-1:0]  hue_q;
  logic [CNT_W-1:0]              rain_total_q, rain_total_d;
  logic [CNT_W-1:0]              pixel_total_q, pixel_total_d;
  logic                          out_valid_q;
  rgbhue_pkg::res_t              out_q;

  // Pixel decode.
  logic [4:0]        red, blue, grn_half, hi, lo, spread;
  logic [5:0]        grn;
  logic              grey;
  logic signed [7:0] diff;
  logic [7:0]        diff_abs;
  logic [8:0]        base;

  always_comb begin
    red      = pix_q[15:11];
    grn      = pix_q[10:5];
    blue     = pix_q[4:0];
    grn_half = grn[5:1];
    hi = (red > grn_half) ? ((red > blue) ? red : blue) : ((grn_half > blue) ? grn_half : blue);
    lo = (red < grn_half) ? ((red < blue) ? red : blue) : ((grn_half < blue) ? grn_half : blue);
    spread = hi - lo;
    grey   = (spread == '0) || (spread < thr_q);
    priority if (hi == red) begin
      diff = $signed({2'b00, grn}) - $signed({2'b00, blue, 1'b0});
      base = rgbhue_pkg::HUE_BASE_RED;
    end else if (hi == grn_half) begin
      diff = $signed({2'b00, blue, 1'b0}) - $signed({2'b00, red, 1'b0});
      base = rgbhue_pkg::HUE_BASE_GREEN;
    end else begin
      diff = $signed({2'b00, red, 1'b0}) - $signed({2'b00, grn});
      base = rgbhue_pkg::HUE_BASE_BLUE;
    end
    diff_abs = diff[7] ? 8'(-diff) : 8'(diff);
  end

  // Divider operands: the hue offset, or the rain share times 100.
  logic [DIV_W-1:0]            div_num;
  logic [DEN_W-1:0]            div_den;
  logic [DIV_W-1:0]            rain_wide;
  logic [rgbhue_pkg::Q_W-1:0]  quot;

  always_comb begin
    rain_wide = DIV_W'(rain_total_q);
    if (cmd_i.load_pct) begin
      div_num = (rain_wide << 6) + (rain_wide << 5) + (rain_wide << 2);
      div_den = DEN_W'(pixel_total_q);
    end else begin
      div_num = DIV_W'({diff_abs[6:0], 5'b00000});
      div_den = DEN_W'({spread, 1'b0});
    end
  end

  rgbhue_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load_hue | cmd_i.load_pct),
    .step_i     (cmd_i.div_step),
    .step_idx_i (cmd_i.step_idx),
    .num_i      (div_num),
    .den_i      (div_den),
    .quot_o     (quot)
  );

  // Hue from the quotient, wrapped onto the circle.
  logic signed [8:0] quot_s, hue_raw;
  logic [8:0]        hue_wrap;

  always_comb begin
    quot_s  = $signed({2'b00, quot});
    hue_raw = neg_q ? ($signed(base_q) - quot_s) : ($signed(base_q) + quot_s);
    hue_wrap = 9'(hue_raw);
    if (hue_raw < 0) begin
      hue_wrap = 9'(hue_raw + $signed(rgbhue_pkg::HUE_CIRCLE));
    end else if (hue_wrap >= rgbhue_pkg::HUE_CIRCLE) begin
      hue_wrap = hue_wrap - rgbhue_pkg::HUE_CIRCLE;
    end
  end

  always_comb begin
    pixel_total_d = pixel_total_q;
    rain_total_d  = rain_total_q;
    if (cmd_i.cnt_clear) begin
      pixel_total_d = '0;
      rain_total_d  = '0;
    end else if (cmd_i.cnt_update) begin
      if (pixel_total_q < CNT_MAX) begin
        pixel_total_d = pixel_total_q + 1'b1;
      end
      if (!grey && (rain_total_q < CNT_MAX)) begin
        rain_total_d = rain_total_q + 1'b1;
      end
    end
  end

  logic [CNT_W+rgbhue_pkg::RCOUNT_W-1:0] rain_ext;
  assign rain_ext = {{rgbhue_pkg::RCOUNT_W{1'b0}}, rain_total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= rgbhue_pkg::GREY_THR_RESET;
      rain_total_q  <= '0;
      pixel_total_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      rain_total_q  <= rain_total_d;
      pixel_total_q <= pixel_total_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q  <= in_data_i.pixel;
      last_q <= in_data_i.last_in_frame;
    end
    if (cmd_i.load_hue) begin
      grey_q <= grey;
      neg_q  <= diff[7];
      base_q <= base;
    end
    if (cmd_i.hue_save) begin
      hue_q <= grey_q ? rgbhue_pkg::HUE_GREY : hue_wrap[7:0];
    end
    if (cmd_i.out_load) begin
      out_q.hue           <= hue_q;
      out_q.is_rain       <= (hue_q != rgbhue_pkg::HUE_GREY);
      out_q.rain_count    <= rain_ext[rgbhue_pkg::RCOUNT_W-1:0];
      out_q.cover_percent <= last_q ? quot : '0;
      out_q.frame_done    <= last_q;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  `RGBHUE_ASSERT(a_rain_le_pix, rain_total_q <= pixel_total_q)
  `RGBHUE_ASSERT_IMP(a_hue_on_circle, out_valid_q && out_q.is_rain,
                     out_q.hue < rgbhue_pkg::HUE_CIRCLE[7:0])

endmodule

>>> tb/sv/tb_rgb565_hue_rain_counter.sv
module tb_rgb565_hue_rain_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhue_pkg::*;

  localparam int unsigned FRAME_LIMIT = MAX_PIXELS_DEFAULT;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_WAIT    = 13;
  localparam int unsigned THR_PLAN [8] = '{10, 0, 31, 7, 1, 30, 20, 5};

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pix_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  res_t     out_data_o;
  logic     cfg_we_i    = 1'b0;
  logic [THR_W-1:0] cfg_data_i = '0;

  rgb565_hue_rain_counter #(
    .MAX_PIXELS (FRAME_LIMIT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  pix_in_t          pending_pixels [$];
  res_t             awaited_results [$];
  logic [THR_W-1:0] grey_thr     = GREY_THR_RESET;
  int unsigned      frame_rain   = 0;
  int unsigned      frame_pixels = 0;
  int unsigned      mismatches   = 0;

  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  hold_req   = 0;
  int  hold_seen  = 0;
  int  hold_left  = 0;
  int  rx_wait    = 0;
  int  tx_gap     = 0;
  logic tx_next_valid;
  res_t want;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [HUE_W-1:0] hue_from_rgb(logic [PIXEL_W-1:0] px,
                                                     logic [THR_W-1:0] thr);
    int r, g, b, gn, hi, lo, spread, den, h;
    r  = px[15:11];
    g  = px[10:5];
    b  = px[4:0];
    gn = g / 2;
    hi = (r > gn) ? ((r > b) ? r : b) : ((gn > b) ? gn : b);
    lo = (r < gn) ? ((r < b) ? r : b) : ((gn < b) ? gn : b);
    spread = hi - lo;
    // A flat pixel has no hue even at threshold zero, so the divisor is never zero.
    if (spread == 0 || spread < int'(thr)) begin
      return HUE_GREY;
    end
    den = spread * 2;
    if (hi == r) begin
      h = int'(HUE_BASE_RED) + ((g - b * 2) * 32) / den;
    end else if (hi == gn) begin
      h = int'(HUE_BASE_GREEN) + ((b * 2 - r * 2) * 32) / den;
    end else begin
      h = int'(HUE_BASE_BLUE) + ((r * 2 - g) * 32) / den;
    end
    if (h < 0) begin
      h += int'(HUE_CIRCLE);
    end
    return HUE_W'(h % int'(HUE_CIRCLE));
  endfunction

  // Works out the result of one pixel and advances the frame counters.
  function automatic res_t classify_pixel(pix_in_t beat);
    res_t             res;
    longint unsigned  pct;
    res.hue     = hue_from_rgb(beat.pixel, grey_thr);
    res.is_rain = (res.hue != HUE_GREY);
    if (frame_pixels < FRAME_LIMIT) begin
      frame_pixels++;
    end
    if (res.is_rain && frame_rain < FRAME_LIMIT) begin
      frame_rain++;
    end
    res.rain_count = RCOUNT_W'(frame_rain);
    pct = 0;
    if (beat.last_in_frame) begin
      if (frame_pixels != 0) begin
        pct = (longint'(frame_rain) * 100) / frame_pixels;
      end
      frame_rain   = 0;
      frame_pixels = 0;
    end
    res.cover_percent = PCT_W'(pct);
    res.frame_done    = beat.last_in_frame;
    return res;
  endfunction

  function automatic logic [PIXEL_W-1:0] draw_pixel();
    int kind, base, r, gn, b;
    logic [PIXEL_W-1:0] px;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      px = PIXEL_W'($urandom_range(0, 65535));
    end else if (kind == 9) begin
      px = {5'($urandom_range(0, 1) * 31), 6'($urandom_range(0, 1) * 63),
            5'($urandom_range(0, 1) * 31)};
    end else begin
      // Channels close together, so that the spread lands around the threshold.
      base = $urandom_range(0, 31);
      r  = base + $urandom_range(0, 12);
      gn = base + $urandom_range(0, 12);
      b  = base + $urandom_range(0, 12);
      if (r > 31) r = 31;
      if (gn > 31) gn = 31;
      if (b > 31) b = 31;
      px = {5'(r), 6'(gn * 2 + $urandom_range(0, 1)), 5'(b)};
    end
    return px;
  endfunction

  task automatic queue_pixel(logic [PIXEL_W-1:0] px, logic last);
    pix_in_t beat;
    beat.pixel         = px;
    beat.last_in_frame = last;
    pending_pixels.push_back(beat);
  endtask

  // Sampled at the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_pixels.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Pixel driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap      = 0;
    end else begin
      tx_next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        tx_next_valid = 1'b0;
        tx_gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (!tx_next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_pixels.size() != 0) begin
          in_data_i    <= pending_pixels.pop_front();
          tx_next_valid = 1'b1;
        end
      end
      in_valid_i <= tx_next_valid;
    end
  end

  // Result receiver; a new hold request keeps it stalled for a long stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait      = 0;
      hold_left    = 0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (out_valid_o && !out_stall_i) begin
        rx_wait = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  // Checks result beats first, then predicts the pixel beat of the same edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      grey_thr     = GREY_THR_RESET;
      frame_rain   = 0;
      frame_pixels = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: hue %0d rain %0b count %0d pct %0d done %0b",
                     out_data_o.hue, out_data_o.is_rain, out_data_o.rain_count,
                     out_data_o.cover_percent, out_data_o.frame_done);
          end
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.hue !== want.hue || out_data_o.is_rain !== want.is_rain ||
              out_data_o.rain_count !== want.rain_count ||
              out_data_o.cover_percent !== want.cover_percent ||
              out_data_o.frame_done !== want.frame_done) begin
            if (mismatches < 10) begin
              $display("mismatch: hue %0d/%0d rain %0b/%0b count %0d/%0d pct %0d/%0d done %0b/%0b",
                       want.hue, out_data_o.hue, want.is_rain, out_data_o.is_rain,
                       want.rain_count, out_data_o.rain_count,
                       want.cover_percent, out_data_o.cover_percent,
                       want.frame_done, out_data_o.frame_done);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(classify_pixel(in_data_i));
      end
      if (cfg_we_i) begin
        grey_thr = cfg_data_i;
      end
    end
  end

  initial begin
    int ph, made, len, i;
    bit noisy;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset threshold: primaries, secondaries, greys and the negative hue wrap.
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'hF800, 1'b0);
    queue_pixel(16'h07E0, 1'b0);
    queue_pixel(16'h001F, 1'b0);
    queue_pixel(16'hFFE0, 1'b0);
    queue_pixel(16'h07FF, 1'b0);
    queue_pixel(16'hF81F, 1'b0);
    queue_pixel(16'hF80A, 1'b0);
    queue_pixel(16'h0020, 1'b0);
    queue_pixel(16'h4800, 1'b0);
    queue_pixel(16'h5000, 1'b0);
    queue_pixel(16'h8410, 1'b1);
    queue_pixel(16'hF800, 1'b1);
    queue_pixel(16'h0000, 1'b1);
    wait_idle();

    // Threshold zero: a flat pixel still has no hue, a spread of one does.
    set_threshold(5'd0);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'h0800, 1'b0);
    queue_pixel(16'h0040, 1'b0);
    queue_pixel(16'h0001, 1'b0);
    queue_pixel(16'hFFFF, 1'b1);
    wait_idle();

    set_threshold(5'd31);
    queue_pixel(16'hF800, 1'b0);
    queue_pixel(16'h07E0, 1'b0);
    queue_pixel(16'h001F, 1'b0);
    queue_pixel(16'h7800, 1'b1);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      set_threshold((ph == 3 || ph == 6) ? THR_W'($urandom_range(0, 31)) :
                    THR_W'(THR_PLAN[ph]));
      tx_idle_on = (ph % 3 != 1) && (ph != 2);
      rx_idle_on = (ph % 4 != 2);
      noisy      = (ph % 2 == 1);
      if (ph == 2) begin
        // The sender keeps offering while the receiver holds off.
        hold_req++;
      end
      made = 0;
      while (made < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(41, 60);
          1, 2:    len = $urandom_range(20, 40);
          default: len = $urandom_range(1, 12);
        endcase
        for (i = 0; i < len; i++) begin
          queue_pixel(draw_pixel(), (i == len - 1) || (noisy && $urandom_range(0, 9) == 0));
        end
        made += len;
      end
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("rgb565_hue_rain_counter verification clean");
    end else begin
      $display("rgb565_hue_rain_counter verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("rgb565_hue_rain_counter verification failed");
    $finish;
  end

endmodule
